[rtl/tpag_pkg.sv]
// ----------------------------------------------------------------------------
// tpag_pkg
// Shared constants, register indexes and types of the tensor permute
// address generator.
// ----------------------------------------------------------------------------
package tpag_pkg;

   localparam int MAX_DIMS       = 6;
   localparam int EXTENT_BITS    = 8;
   localparam int ADDR_BITS      = 20;
   localparam int MAP_BITS       = 3;
   localparam int DIM_COUNT_BITS = 3;
   localparam int VALUE_BITS     = 64;
   localparam int CSR_INDEX_BITS = 2;
   localparam int MAP_MAX_DIMS   = 8;

   localparam logic [DIM_COUNT_BITS-1:0] DIM_COUNT_RESET = DIM_COUNT_BITS'(2);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DIM_COUNT = 2'd0,
      CSR_WIDTHS    = 2'd1,
      CSR_PERM_MAP  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic load_term;
      logic clear_digit;
   } term_ctl_type;

   function automatic logic [MAP_BITS*MAP_MAX_DIMS-1:0] identity_map(input int dims);
      logic [MAP_BITS*MAP_MAX_DIMS-1:0] res;
      res = '0;
      for (int i = 0; i < MAP_MAX_DIMS; i++) begin
         if (i < dims) begin
            res[i*MAP_BITS +: MAP_BITS] = MAP_BITS'(i);
         end
      end
      return res;
   endfunction

endpackage

[rtl/tpag_rebuild.sv]
// ----------------------------------------------------------------------------
// tpag_rebuild
// Configuration sequencer: checks the configuration, computes the output
// strides and reloads the per-dimension address terms with one shared
// multiplier.
// ----------------------------------------------------------------------------
module tpag_rebuild #(
   parameter int MAX_DIMS    = tpag_pkg::MAX_DIMS,
   parameter int EXTENT_BITS = tpag_pkg::EXTENT_BITS,
   parameter int ADDR_BITS   = tpag_pkg::ADDR_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        cfg_written,
   input  logic [tpag_pkg::DIM_COUNT_BITS-1:0]         dim_count,
   input  logic [MAX_DIMS*EXTENT_BITS-1:0]             widths,
   input  logic [MAX_DIMS*tpag_pkg::MAP_BITS-1:0]      perm,
   input  logic [MAX_DIMS*EXTENT_BITS-1:0]             digits,
   output logic                                        busy,
   output logic                                        cfg_bad,
   output logic [$clog2(MAX_DIMS+1)-1:0]               active_dims,
   output logic [MAX_DIMS*ADDR_BITS-1:0]               strides,
   output tpag_pkg::term_ctl_type                      term_ctl,
   output logic [$clog2(MAX_DIMS)-1:0]                 term_idx,
   output logic [ADDR_BITS-1:0]                        term_value
);

   localparam int DIM_W  = $clog2(MAX_DIMS);
   localparam int CNT_W  = $clog2(MAX_DIMS+1);
   localparam int MB     = tpag_pkg::MAP_BITS;
   localparam int CMP_W  = (CNT_W > MB) ? CNT_W : MB;
   localparam int EXT_W  = EXTENT_BITS + 1;
   localparam int ACC_W  = ADDR_BITS + 1;
   localparam int PROD_W = ACC_W + EXT_W;
   localparam logic [PROD_W-1:0] ADDR_SPACE = PROD_W'(1) << ADDR_BITS;
   localparam logic [DIM_W-1:0]  LAST_DIM   = DIM_W'(MAX_DIMS - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_TOTAL  = 4'b0010,
      ST_STRIDE = 4'b0100,
      ST_TERM   = 4'b1000
   } rb_state_type;

   rb_state_type          state_ff, state_in;
   logic                  start_ff;
   logic [DIM_W-1:0]      k_ff, k_in;
   logic [DIM_W-1:0]      i_ff, i_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic                  bad_ff, bad_in;
   logic [ADDR_BITS-1:0]  stride_ff [MAX_DIMS];
   logic [ADDR_BITS-1:0]  stride_in;
   logic                  stride_we;

   logic [CNT_W-1:0]      n;
   logic                  range_bad;
   logic                  map_bad;
   logic [EXT_W-1:0]      ext [MAX_DIMS];
   logic [MB-1:0]         map [MAX_DIMS];
   logic [ACC_W-1:0]      mul_a;
   logic [EXT_W-1:0]      mul_b;
   logic [PROD_W-1:0]     prod;
   logic [ADDR_BITS-1:0]  s_next;
   logic                  k_active;
   logic                  i_active;

   always_comb begin
      if (dim_count < tpag_pkg::DIM_COUNT_BITS'(2)) begin
         n         = CNT_W'(2);
         range_bad = 1'b1;
      end else if ({1'b0, dim_count} > (tpag_pkg::DIM_COUNT_BITS+1)'(MAX_DIMS)) begin
         n         = CNT_W'(MAX_DIMS);
         range_bad = 1'b1;
      end else begin
         n         = CNT_W'(dim_count);
         range_bad = 1'b0;
      end
   end

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         ext[d] = {1'b0, widths[d*EXTENT_BITS +: EXTENT_BITS]} + EXT_W'(1);
         map[d] = perm[d*MB +: MB];
      end
   end

   always_comb begin
      map_bad = 1'b0;
      for (int a = 0; a < MAX_DIMS; a++) begin
         if (CNT_W'(a) < n) begin
            if (CMP_W'(map[a]) >= CMP_W'(n)) begin
               map_bad = 1'b1;
            end
            for (int b = 0; b < a; b++) begin
               if (map[b] == map[a]) begin
                  map_bad = 1'b1;
               end
            end
         end
      end
   end

   assign k_active = CNT_W'(k_ff) < n;
   assign i_active = CNT_W'(i_ff) < n;

   always_comb begin
      unique case (state_ff)
         ST_TOTAL, ST_STRIDE: begin
            mul_a = acc_ff;
            mul_b = ext[k_ff];
         end
         ST_TERM: begin
            mul_a = {1'b0, stride_ff[i_ff]};
            mul_b = {1'b0, digits[i_ff*EXTENT_BITS +: EXTENT_BITS]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign s_next = (k_active && (map[k_ff] > map[i_ff])) ? prod[ADDR_BITS-1:0]
                                                        : acc_ff[ADDR_BITS-1:0];

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      i_in       = i_ff;
      acc_in     = acc_ff;
      bad_in     = bad_ff;
      stride_we  = 1'b0;
      stride_in  = '0;
      term_ctl   = '0;
      term_value = prod[ADDR_BITS-1:0];
      if (start_ff) begin
         state_in = ST_TOTAL;
         k_in     = '0;
         i_in     = '0;
         acc_in   = ACC_W'(1);
         bad_in   = range_bad | map_bad;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
            end
            ST_TOTAL: begin
               if (prod > ADDR_SPACE) begin
                  bad_in   = 1'b1;
                  state_in = ST_STRIDE;
                  k_in     = '0;
                  acc_in   = ACC_W'(1);
               end else if (CNT_W'(k_ff) == n - CNT_W'(1)) begin
                  state_in = ST_STRIDE;
                  k_in     = '0;
                  acc_in   = ACC_W'(1);
               end else begin
                  acc_in = prod[ACC_W-1:0];
                  k_in   = k_ff + DIM_W'(1);
               end
            end
            ST_STRIDE: begin
               if (k_ff == LAST_DIM) begin
                  stride_we = 1'b1;
                  stride_in = i_active ? s_next : '0;
                  state_in  = ST_TERM;
               end else begin
                  acc_in = {1'b0, s_next};
                  k_in   = k_ff + DIM_W'(1);
               end
            end
            ST_TERM: begin
               term_ctl.load_term   = 1'b1;
               term_ctl.clear_digit = !i_active;
               if (i_ff == LAST_DIM) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_STRIDE;
                  i_in     = i_ff + DIM_W'(1);
                  k_in     = '0;
                  acc_in   = ACC_W'(1);
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b1;
         bad_ff   <= 1'b0;
         k_ff     <= '0;
         i_ff     <= '0;
      end else begin
         state_ff <= state_in;
         start_ff <= cfg_written;
         bad_ff   <= bad_in;
         k_ff     <= k_in;
         i_ff     <= i_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (stride_we) begin
         stride_ff[i_ff] <= stride_in;
      end
   end

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         strides[d*ADDR_BITS +: ADDR_BITS] = stride_ff[d];
      end
   end

   assign busy        = start_ff || (state_ff != ST_IDLE);
   assign cfg_bad     = bad_ff;
   assign active_dims = n;
   assign term_idx    = i_ff;

endmodule

[rtl/tpag_odometer.sv]
// ----------------------------------------------------------------------------
// tpag_odometer
// Per-dimension index digits and address terms. One step advances the
// odometer and returns the address and last flag of the current element.
// ----------------------------------------------------------------------------
module tpag_odometer #(
   parameter int MAX_DIMS    = tpag_pkg::MAX_DIMS,
   parameter int EXTENT_BITS = tpag_pkg::EXTENT_BITS,
   parameter int ADDR_BITS   = tpag_pkg::ADDR_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic                               restart,
   input  logic [$clog2(MAX_DIMS+1)-1:0]      active_dims,
   input  logic [MAX_DIMS*EXTENT_BITS-1:0]    widths,
   input  logic [MAX_DIMS*ADDR_BITS-1:0]      strides,
   input  tpag_pkg::term_ctl_type             term_ctl,
   input  logic [$clog2(MAX_DIMS)-1:0]        term_idx,
   input  logic [ADDR_BITS-1:0]               term_value,
   output logic [MAX_DIMS*EXTENT_BITS-1:0]    digits,
   output logic [ADDR_BITS-1:0]               dest,
   output logic                               last
);

   localparam int CNT_W = $clog2(MAX_DIMS+1);

   logic [EXTENT_BITS-1:0] digit_ff [MAX_DIMS];
   logic [EXTENT_BITS-1:0] digit_in [MAX_DIMS];
   logic [ADDR_BITS-1:0]   term_ff  [MAX_DIMS];
   logic [ADDR_BITS-1:0]   term_in  [MAX_DIMS];
   logic [EXTENT_BITS-1:0] cur_digit [MAX_DIMS];
   logic [ADDR_BITS-1:0]   cur_term  [MAX_DIMS];
   logic [MAX_DIMS-1:0]    active;
   logic [MAX_DIMS-1:0]    at_max;
   logic [MAX_DIMS-1:0]    carry;

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         cur_digit[d] = restart ? '0 : digit_ff[d];
         cur_term[d]  = restart ? '0 : term_ff[d];
         active[d]    = CNT_W'(d) < active_dims;
         at_max[d]    = !active[d] ||
                        (cur_digit[d] >= widths[d*EXTENT_BITS +: EXTENT_BITS]);
      end
   end

   always_comb begin
      carry[MAX_DIMS-1] = 1'b1;
      for (int d = MAX_DIMS - 2; d >= 0; d--) begin
         carry[d] = carry[d+1] & at_max[d+1];
      end
   end

   assign last = carry[0] & at_max[0];

   always_comb begin
      dest = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         dest = dest + cur_term[d];
      end
   end

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         digit_in[d] = cur_digit[d];
         term_in[d]  = cur_term[d];
         if (active[d] && carry[d]) begin
            if (at_max[d]) begin
               digit_in[d] = '0;
               term_in[d]  = '0;
            end else begin
               digit_in[d] = cur_digit[d] + EXTENT_BITS'(1);
               term_in[d]  = cur_term[d] + strides[d*ADDR_BITS +: ADDR_BITS];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            digit_ff[d] <= '0;
            term_ff[d]  <= '0;
         end
      end else if (step) begin
         for (int d = 0; d < MAX_DIMS; d++) begin
            digit_ff[d] <= digit_in[d];
            term_ff[d]  <= term_in[d];
         end
      end else if (term_ctl.load_term) begin
         term_ff[term_idx] <= term_value;
         if (term_ctl.clear_digit) begin
            digit_ff[term_idx] <= '0;
         end
      end
   end

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         digits[d*EXTENT_BITS +: EXTENT_BITS] = digit_ff[d];
      end
   end

endmodule

[rtl/tensor_permute_address_gen.sv]
// ----------------------------------------------------------------------------
// tensor_permute_address_gen
// Streaming address generator for an N-dimensional tensor transpose.
// An accepted beat's result is registered and offered in the cycle after it.
// Throughput: one beat per cycle, set by the odometer carry chain, while the
// sequencer is idle and the output is not stalled. After reset and after each
// register write the stride sequencer runs, one multiply a cycle, and the
// input is held off meanwhile.
// Reset is synchronous and active high; registers return to two dimensions,
// unit extents and the identity map.
// ----------------------------------------------------------------------------
module tensor_permute_address_gen #(
   parameter int MAX_DIMS    = tpag_pkg::MAX_DIMS,
   parameter int EXTENT_BITS = tpag_pkg::EXTENT_BITS,
   parameter int ADDR_BITS   = tpag_pkg::ADDR_BITS
) (
   input  logic                                            clock,
   input  logic                                            reset,
   // tdata: element_value
   input  logic [tpag_pkg::VALUE_BITS-1:0]                 req_tdata,
   // tuser: restart
   input  logic                                            req_tuser,
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   // tdata: dest_address, value_out, zero fill
   output logic [((ADDR_BITS+tpag_pkg::VALUE_BITS+7)/8)*8-1:0] rsp_tdata,
   // tuser: config_error
   output logic                                            rsp_tuser,
   output logic                                            rsp_tlast,
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   input  logic                                            csr_we,
   input  logic [tpag_pkg::CSR_INDEX_BITS-1:0]             csr_index,
   input  logic [((MAX_DIMS*EXTENT_BITS > MAX_DIMS*tpag_pkg::MAP_BITS) ?
                  MAX_DIMS*EXTENT_BITS : MAX_DIMS*tpag_pkg::MAP_BITS)-1:0] csr_wdata
);

   localparam int WID_W   = MAX_DIMS * EXTENT_BITS;
   localparam int PERM_W  = MAX_DIMS * tpag_pkg::MAP_BITS;
   localparam int DC_W    = tpag_pkg::DIM_COUNT_BITS;
   localparam int VAL_W   = tpag_pkg::VALUE_BITS;
   localparam int RDATA_W = ((ADDR_BITS + VAL_W + 7) / 8) * 8;
   localparam int PAD_W   = RDATA_W - ADDR_BITS - VAL_W;
   localparam logic [PERM_W-1:0] PERM_RESET =
      PERM_W'(tpag_pkg::identity_map(MAX_DIMS));

   logic [DC_W-1:0]              dim_count_ff;
   logic [WID_W-1:0]             widths_ff;
   logic [PERM_W-1:0]            perm_ff;
   logic                         cfg_written;

   logic                         busy;
   logic                         cfg_bad;
   logic [$clog2(MAX_DIMS+1)-1:0] active_dims;
   logic [MAX_DIMS*ADDR_BITS-1:0] strides;
   tpag_pkg::term_ctl_type       term_ctl;
   logic [$clog2(MAX_DIMS)-1:0]  term_idx;
   logic [ADDR_BITS-1:0]         term_value;
   logic [WID_W-1:0]             digits;
   logic [ADDR_BITS-1:0]         dest;
   logic                         last;

   logic                         accept;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0]         dest_ff;
   logic [VAL_W-1:0]             value_ff;
   logic                         last_ff;
   logic                         err_ff;

   always_comb begin
      cfg_written = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            tpag_pkg::CSR_DIM_COUNT,
            tpag_pkg::CSR_WIDTHS,
            tpag_pkg::CSR_PERM_MAP: cfg_written = 1'b1;
            default:                cfg_written = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= tpag_pkg::DIM_COUNT_RESET;
         widths_ff    <= '0;
         perm_ff      <= PERM_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            tpag_pkg::CSR_DIM_COUNT: dim_count_ff <= csr_wdata[DC_W-1:0];
            tpag_pkg::CSR_WIDTHS:    widths_ff    <= csr_wdata[WID_W-1:0];
            tpag_pkg::CSR_PERM_MAP:  perm_ff      <= csr_wdata[PERM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tpag_rebuild #(
      .MAX_DIMS    (MAX_DIMS),
      .EXTENT_BITS (EXTENT_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_rebuild (
      .clock       (clock),
      .reset       (reset),
      .cfg_written (cfg_written),
      .dim_count   (dim_count_ff),
      .widths      (widths_ff),
      .perm        (perm_ff),
      .digits      (digits),
      .busy        (busy),
      .cfg_bad     (cfg_bad),
      .active_dims (active_dims),
      .strides     (strides),
      .term_ctl    (term_ctl),
      .term_idx    (term_idx),
      .term_value  (term_value)
   );

   tpag_odometer #(
      .MAX_DIMS    (MAX_DIMS),
      .EXTENT_BITS (EXTENT_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_odometer (
      .clock       (clock),
      .reset       (reset),
      .step        (accept),
      .restart     (req_tuser),
      .active_dims (active_dims),
      .widths      (widths_ff),
      .strides     (strides),
      .term_ctl    (term_ctl),
      .term_idx    (term_idx),
      .term_value  (term_value),
      .digits      (digits),
      .dest        (dest),
      .last        (last)
   );

   assign req_tready   = !busy && (!rsp_valid_ff || rsp_tready);
   assign accept       = req_tvalid && req_tready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dest_ff  <= dest;
         value_ff <= req_tdata;
         last_ff  <= last;
         err_ff   <= cfg_bad;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, value_ff, dest_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = err_ff;

`ifndef SYNTHESIS
   a_cfg_holds_input: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_index == tpag_pkg::CSR_DIM_COUNT ||
                  csr_index == tpag_pkg::CSR_WIDTHS ||
                  csr_index == tpag_pkg::CSR_PERM_MAP)) |=> !req_tready)
      else $error("input accepted right after a register write");

   a_restart_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser) |=> (rsp_tvalid && dest_ff == '0))
      else $error("restarted element did not get address zero");

   a_reset_rebuilds: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("input accepted before the strides were built");
`endif

endmodule
